FILE: sv/imhq_pkg.sv
// Shared types, field widths and codes for the indexed min-heap queue.
package imhq_pkg;

    localparam int REQ_W      = 2;
    localparam int ITEM_W     = 10;
    localparam int KEYIO_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 11;
    localparam int ITEM_COUNT = 1024;

    localparam logic [REQ_W-1:0] REQ_INSERT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE_MIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DECREASE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_LOWER = 3'd4;

    // Operand selection of the shared key comparator
    typedef enum logic [1:0] {
        CMP_STORED_GT_NEW = 2'd0,
        CMP_LEFT_GT_RIGHT = 2'd1,
        CMP_MOV_GT_CHILD  = 2'd2
    } cmp_op_t;

endpackage

FILE: sv/imhq_if.sv
// Request and result channel interfaces of the indexed min-heap queue.
interface imhq_req_if;
    logic                           valid;
    logic                           ready;
    logic [imhq_pkg::REQ_W-1:0]     req_type;
    logic [imhq_pkg::ITEM_W-1:0]    item;
    logic [imhq_pkg::KEYIO_W-1:0]   key;

    modport source (output valid, output req_type, output item, output key, input ready);
    modport sink   (input valid, input req_type, input item, input key, output ready);
endinterface

interface imhq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [imhq_pkg::ITEM_W-1:0]    out_item;
    logic [imhq_pkg::KEYIO_W-1:0]   out_key;
    logic [imhq_pkg::STATUS_W-1:0]  status;
    logic [imhq_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output out_item, output out_key, output status,
                    output count, input ready);
    modport sink   (input valid, input out_item, input out_key, input status,
                    input count, output ready);
endinterface

FILE: sv/imhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/imhq_keycmp.sv
// Shared key comparator: select an operand pair and report greater-than.
module imhq_keycmp #(
    parameter int KEY_WIDTH = 16
) (
    input  imhq_pkg::cmp_op_t       op,
    input  logic [KEY_WIDTH-1:0]    new_key,
    input  logic [KEY_WIDTH-1:0]    mem_key,
    input  logic [KEY_WIDTH-1:0]    left_key,
    input  logic [KEY_WIDTH-1:0]    mov_key,
    input  logic [KEY_WIDTH-1:0]    child_key,
    output logic                    gt
);

    logic [KEY_WIDTH-1:0] opa;
    logic [KEY_WIDTH-1:0] opb;

    always_comb
    begin
        unique case (op)
            imhq_pkg::CMP_STORED_GT_NEW:
            begin
                opa = mem_key;
                opb = new_key;
            end
            imhq_pkg::CMP_LEFT_GT_RIGHT:
            begin
                opa = left_key;
                opb = mem_key;
            end
            imhq_pkg::CMP_MOV_GT_CHILD:
            begin
                opa = mov_key;
                opb = child_key;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        gt = (opa > opb);
    end

endmodule

FILE: sv/indexed_min_heap_queue_core.sv
// Indexed binary min-heap priority queue: sequencer, stores and shared comparator.
// Insert/decrease-key write the key and walk the item up toward the root; delete-min takes the
// root item and walks the last item down from the root toward a leaf; refused requests go
// from the check straight to the result. One request at a time; the next is taken the cycle
// after the result is registered, and a stalled result holds the sequencer. Reset: async,
// active low; then a sweep clears the presence map.
module indexed_min_heap_queue_core #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    imhq_req_if.sink    request,
    imhq_rsp_if.source  result
);

    localparam int ITEM_W     = imhq_pkg::ITEM_W;
    localparam int ITEM_COUNT = imhq_pkg::ITEM_COUNT;
    localparam int KEYIO_W    = imhq_pkg::KEYIO_W;
    localparam int COUNT_W    = imhq_pkg::COUNT_W;
    localparam int SLOT_DEPTH = CAPACITY + 1;
    localparam int SLOT_W     = $clog2(SLOT_DEPTH);
    localparam logic [SLOT_W-1:0] CAP_SLOT  = SLOT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] ONE_SLOT  = SLOT_W'(1);
    localparam logic [ITEM_W-1:0] LAST_ITEM = ITEM_W'(ITEM_COUNT - 1);

    // Sequencer states, one-hot
    typedef enum logic [14:0] {
        S_CLEAR  = 15'h0001,
        S_IDLE   = 15'h0002,
        S_CHECK  = 15'h0004,
        S_UP_PAR = 15'h0008,
        S_UP_CMP = 15'h0010,
        S_D_ROOT = 15'h0020,
        S_D_LAST = 15'h0040,
        S_D_LKEY = 15'h0080,
        S_DN_L   = 15'h0100,
        S_DN_R   = 15'h0200,
        S_DN_RK  = 15'h0400,
        S_DN_CMP = 15'h0800,
        S_FIN    = 15'h1000,
        S_DONE   = 15'h2000,
        S_SPARE  = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    // Control registers
    logic [ITEM_W-1:0]  clr_reg, clr_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Request and working registers (payload, no reset)
    logic [imhq_pkg::REQ_W-1:0]     req_reg, req_next;
    logic [ITEM_W-1:0]              item_reg, item_next;
    logic [KEY_WIDTH-1:0]           key_reg, key_next;
    logic [SLOT_W-1:0]              s_reg, s_next;
    logic [ITEM_W-1:0]              mov_item_reg, mov_item_next;
    logic [KEY_WIDTH-1:0]           mov_key_reg, mov_key_next;
    logic [ITEM_W-1:0]              par_item_reg, par_item_next;
    logic [ITEM_W-1:0]              left_item_reg, left_item_next;
    logic [KEY_WIDTH-1:0]           left_key_reg, left_key_next;
    logic [ITEM_W-1:0]              right_item_reg, right_item_next;
    logic [ITEM_W-1:0]              child_item_reg, child_item_next;
    logic [KEY_WIDTH-1:0]           child_key_reg, child_key_next;
    logic [SLOT_W-1:0]              child_slot_reg, child_slot_next;
    logic [ITEM_W-1:0]              res_item_reg, res_item_next;
    logic [KEY_WIDTH-1:0]           res_key_reg, res_key_next;
    logic [imhq_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;

    // Output register
    logic [ITEM_W-1:0]              out_item_reg, out_item_next;
    logic [KEYIO_W-1:0]             out_key_reg, out_key_next;
    logic [imhq_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [COUNT_W-1:0]             out_count_reg, out_count_next;

    // Store ports
    logic                   heap_we;
    logic [SLOT_W-1:0]      heap_waddr;
    logic [ITEM_W-1:0]      heap_wdata;
    logic [SLOT_W-1:0]      heap_raddr;
    logic [ITEM_W-1:0]      heap_rdata;

    logic                   pos_we;
    logic [ITEM_W-1:0]      pos_waddr;
    logic [SLOT_W-1:0]      pos_wdata;
    logic [ITEM_W-1:0]      pos_raddr;
    logic [SLOT_W-1:0]      pos_rdata;

    logic                   keys_we;
    logic [ITEM_W-1:0]      keys_waddr;
    logic [KEY_WIDTH-1:0]   keys_wdata;
    logic [ITEM_W-1:0]      keys_raddr;
    logic [KEY_WIDTH-1:0]   keys_rdata;

    logic                   inh_we;
    logic [ITEM_W-1:0]      inh_waddr;
    logic [0:0]             inh_wdata;
    logic [ITEM_W-1:0]      inh_raddr;
    logic [0:0]             inh_rdata;

    // Comparator
    imhq_pkg::cmp_op_t      cmp_op;
    logic                   cmp_gt;

    // Width conversions and child slot arithmetic
    logic [KEY_WIDTH+KEYIO_W-1:0]   key_in_ext;
    logic [KEY_WIDTH-1:0]           key_in;
    logic [KEY_WIDTH+KEYIO_W-1:0]   res_key_ext;
    logic [SLOT_W+COUNT_W-1:0]      cnt_ext;
    logic [SLOT_W:0]                cnt_wide;
    logic [SLOT_W:0]                c_cur;
    logic [SLOT_W:0]                c_child;
    logic [SLOT_W-1:0]              c_lo;
    logic [SLOT_W-1:0]              c_hi;
    logic                           up_start;
    logic [SLOT_W-1:0]              up_slot;

    // Mask or widen the incoming key to the stored key width
    assign key_in_ext  = {{KEY_WIDTH{1'b0}}, request.key};
    assign key_in      = key_in_ext[KEY_WIDTH-1:0];
    assign res_key_ext = {{KEYIO_W{1'b0}}, res_key_reg};
    assign cnt_ext     = {{COUNT_W{1'b0}}, cnt_reg};
    assign cnt_wide    = {1'b0, cnt_reg};

    // Left child of the hole slot and of the chosen child slot
    assign c_cur   = {s_reg, 1'b0};
    assign c_child = {child_slot_reg, 1'b0};
    assign c_lo    = c_cur[SLOT_W-1:0];
    assign c_hi    = c_lo | ONE_SLOT;

    assign request.ready   = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.out_item = out_item_reg;
    assign result.out_key  = out_key_reg;
    assign result.status   = out_status_reg;
    assign result.count    = out_count_reg;

    // Heap slots 1..CAPACITY hold items; slot 0 is never used
    imhq_ram #(.WIDTH(ITEM_W), .DEPTH(SLOT_DEPTH)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    // Heap slot of each present item
    imhq_ram #(.WIDTH(SLOT_W), .DEPTH(ITEM_COUNT)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Key of each present item
    imhq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(ITEM_COUNT)) u_key_ram (
        .clk   (clk),
        .we    (keys_we),
        .waddr (keys_waddr),
        .wdata (keys_wdata),
        .raddr (keys_raddr),
        .rdata (keys_rdata)
    );

    // Presence map, swept to zero after reset
    imhq_ram #(.WIDTH(1), .DEPTH(ITEM_COUNT)) u_inh_ram (
        .clk   (clk),
        .we    (inh_we),
        .waddr (inh_waddr),
        .wdata (inh_wdata),
        .raddr (inh_raddr),
        .rdata (inh_rdata)
    );

    imhq_keycmp #(.KEY_WIDTH(KEY_WIDTH)) u_keycmp (
        .op        (cmp_op),
        .new_key   (key_reg),
        .mem_key   (keys_rdata),
        .left_key  (left_key_reg),
        .mov_key   (mov_key_reg),
        .child_key (child_key_reg),
        .gt        (cmp_gt)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !result.ready;

        req_next        = req_reg;
        item_next       = item_reg;
        key_next        = key_reg;
        s_next          = s_reg;
        mov_item_next   = mov_item_reg;
        mov_key_next    = mov_key_reg;
        par_item_next   = par_item_reg;
        left_item_next  = left_item_reg;
        left_key_next   = left_key_reg;
        right_item_next = right_item_reg;
        child_item_next = child_item_reg;
        child_key_next  = child_key_reg;
        child_slot_next = child_slot_reg;
        res_item_next   = res_item_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;

        out_item_next   = out_item_reg;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        // Lookups by the item on the request port while idle
        heap_we    = 1'b0;
        heap_waddr = s_reg;
        heap_wdata = mov_item_reg;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = mov_item_reg;
        pos_wdata  = s_reg;
        pos_raddr  = request.item;
        keys_we    = 1'b0;
        keys_waddr = item_reg;
        keys_wdata = key_reg;
        keys_raddr = request.item;
        inh_we     = 1'b0;
        inh_waddr  = item_reg;
        inh_wdata  = 1'b0;
        inh_raddr  = request.item;

        cmp_op     = imhq_pkg::CMP_STORED_GT_NEW;
        up_start   = 1'b0;
        up_slot    = s_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                inh_we    = 1'b1;
                inh_waddr = clr_reg;
                inh_wdata = 1'b0;
                clr_next  = clr_reg + ITEM_W'(1);
                if (clr_reg == LAST_ITEM)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (request.valid)
                begin
                    req_next   = request.req_type;
                    item_next  = request.item;
                    key_next   = key_in;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                // Presence, stored key and slot of the item are on the read ports
                res_item_next   = item_reg;
                res_key_next    = '0;
                res_status_next = imhq_pkg::ST_OK;
                mov_item_next   = item_reg;
                mov_key_next    = key_reg;
                state_next      = S_DONE;
                unique case (req_reg)
                    imhq_pkg::REQ_INSERT:
                    begin
                        if (inh_rdata[0])
                        begin
                            res_key_next    = keys_rdata;
                            res_status_next = imhq_pkg::ST_CONFLICT;
                        end
                        else if (cnt_reg == CAP_SLOT)
                        begin
                            res_status_next = imhq_pkg::ST_CONFLICT;
                        end
                        else
                        begin
                            cnt_next     = cnt_reg + ONE_SLOT;
                            keys_we      = 1'b1;
                            inh_we       = 1'b1;
                            inh_wdata    = 1'b1;
                            res_key_next = key_reg;
                            up_start     = 1'b1;
                            up_slot      = cnt_reg + ONE_SLOT;
                        end
                    end
                    imhq_pkg::REQ_DECREASE:
                    begin
                        if (!inh_rdata[0])
                        begin
                            res_status_next = imhq_pkg::ST_ABSENT;
                        end
                        else if (!cmp_gt)
                        begin
                            res_key_next    = keys_rdata;
                            res_status_next = imhq_pkg::ST_NOT_LOWER;
                        end
                        else
                        begin
                            keys_we      = 1'b1;
                            res_key_next = key_reg;
                            up_start     = 1'b1;
                            up_slot      = pos_rdata;
                        end
                    end
                    imhq_pkg::REQ_DELETE_MIN:
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_item_next   = '0;
                            res_status_next = imhq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            heap_raddr = ONE_SLOT;
                            state_next = S_D_ROOT;
                        end
                    end
                    default:
                    begin
                        res_key_next = inh_rdata[0] ? keys_rdata : '0;
                    end
                endcase

                // Start the upward walk with the item as the moving entry
                if (up_start)
                begin
                    s_next = up_slot;
                    if (up_slot > ONE_SLOT)
                    begin
                        heap_raddr = up_slot >> 1;
                        state_next = S_UP_PAR;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_UP_PAR:
            begin
                par_item_next = heap_rdata;
                keys_raddr    = heap_rdata;
                state_next    = S_UP_CMP;
            end

            S_UP_CMP:
            begin
                // Parent key against the moving key; move the parent down into the hole
                cmp_op = imhq_pkg::CMP_STORED_GT_NEW;
                if (cmp_gt)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = s_reg;
                    heap_wdata = par_item_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = par_item_reg;
                    pos_wdata  = s_reg;
                    s_next     = s_reg >> 1;
                    if ((s_reg >> 1) > ONE_SLOT)
                    begin
                        heap_raddr = s_reg >> 2;
                        state_next = S_UP_PAR;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_D_ROOT:
            begin
                res_item_next = heap_rdata;
                keys_raddr    = heap_rdata;
                heap_raddr    = cnt_reg;
                inh_we        = 1'b1;
                inh_waddr     = heap_rdata;
                inh_wdata     = 1'b0;
                state_next    = S_D_LAST;
            end

            S_D_LAST:
            begin
                res_key_next  = keys_rdata;
                mov_item_next = heap_rdata;
                keys_raddr    = heap_rdata;
                cnt_next      = cnt_reg - ONE_SLOT;
                s_next        = ONE_SLOT;
                state_next    = S_D_LKEY;
            end

            S_D_LKEY:
            begin
                mov_key_next = keys_rdata;
                if (c_cur <= cnt_wide)
                begin
                    heap_raddr = c_lo;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DN_L:
            begin
                left_item_next = heap_rdata;
                keys_raddr     = heap_rdata;
                heap_raddr     = c_hi;
                state_next     = S_DN_R;
            end

            S_DN_R:
            begin
                left_key_next   = keys_rdata;
                right_item_next = heap_rdata;
                keys_raddr      = heap_rdata;
                state_next      = S_DN_RK;
            end

            S_DN_RK:
            begin
                // Right child wins only when it exists and the left key is greater
                cmp_op = imhq_pkg::CMP_LEFT_GT_RIGHT;
                if ((c_cur < cnt_wide) && cmp_gt)
                begin
                    child_item_next = right_item_reg;
                    child_key_next  = keys_rdata;
                    child_slot_next = c_hi;
                end
                else
                begin
                    child_item_next = left_item_reg;
                    child_key_next  = left_key_reg;
                    child_slot_next = c_lo;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                cmp_op = imhq_pkg::CMP_MOV_GT_CHILD;
                if (cmp_gt)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = s_reg;
                    heap_wdata = child_item_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = child_item_reg;
                    pos_wdata  = s_reg;
                    s_next     = child_slot_reg;
                    if (c_child <= cnt_wide)
                    begin
                        heap_raddr = c_child[SLOT_W-1:0];
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // Drop the moving item into the final hole
                heap_we    = 1'b1;
                heap_waddr = s_reg;
                heap_wdata = mov_item_reg;
                pos_we     = 1'b1;
                pos_waddr  = mov_item_reg;
                pos_wdata  = s_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = res_item_reg;
                    out_key_next    = res_key_ext[KEYIO_W-1:0];
                    out_status_next = res_status_reg;
                    out_count_next  = cnt_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        item_reg       <= item_next;
        key_reg        <= key_next;
        s_reg          <= s_next;
        mov_item_reg   <= mov_item_next;
        mov_key_reg    <= mov_key_next;
        par_item_reg   <= par_item_next;
        left_item_reg  <= left_item_next;
        left_key_reg   <= left_key_next;
        right_item_reg <= right_item_next;
        child_item_reg <= child_item_next;
        child_key_reg  <= child_key_next;
        child_slot_reg <= child_slot_next;
        res_item_reg   <= res_item_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        out_item_reg   <= out_item_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule

FILE: sv/imhq_checker.sv
// Port-level checks of the indexed min-heap queue and their bind.
module imhq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [imhq_pkg::ITEM_W-1:0]      rsp_item,
    input logic [imhq_pkg::KEYIO_W-1:0]     rsp_key,
    input logic [imhq_pkg::STATUS_W-1:0]    rsp_status,
    input logic [imhq_pkg::COUNT_W-1:0]     rsp_count
);

    localparam logic [imhq_pkg::COUNT_W-1:0] MAX_COUNT =
        imhq_pkg::COUNT_W'(imhq_pkg::ITEM_COUNT);

    // A stalled result transaction holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item) && $stable(rsp_key)
            && $stable(rsp_status) && $stable(rsp_count))
        else $error("result payload changed while stalled");

    // One request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in work");

    // An empty refusal reports an empty heap and zero fields
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == imhq_pkg::ST_EMPTY) |->
            (rsp_count == '0) && (rsp_item == '0) && (rsp_key == '0))
        else $error("empty status with nonzero fields");

    // The heap never holds more items than there are item numbers
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= MAX_COUNT)
        else $error("count beyond item range");

endmodule

bind indexed_min_heap_queue_core imhq_checker u_imhq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (result.valid),
    .rsp_ready  (result.ready),
    .rsp_item   (result.out_item),
    .rsp_key    (result.out_key),
    .rsp_status (result.status),
    .rsp_count  (result.count)
);
